/* rtl/brs_pkg.sv */
// Shared constants, codes and control types of the block distribution range splitter.
package brs_pkg;

    // Field and register widths.
    localparam int INDEX_BITS    = 32;
    localparam int BYTE_BITS     = 44;
    localparam int RANK_BITS     = 6;
    localparam int RCNT_BITS     = 7;
    localparam int EB_BITS       = 13;
    localparam int MAX_RANKS     = 64;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // Element counts can reach 2^INDEX_BITS, so they carry one extra bit.
    localparam int CNT_BITS        = INDEX_BITS + 1;
    localparam int NB_PROD_BITS    = CNT_BITS + EB_BITS;
    localparam int TOFF_PROD_BITS  = INDEX_BITS + EB_BITS;
    localparam int SPLIT_PROD_BITS = RANK_BITS + CNT_BITS;

    // Divider step counts: a full division for the per-rank split, and a short one
    // for index lookups whose quotient is a rank number.
    localparam int LONG_STEPS  = INDEX_BITS;
    localparam int SHORT_STEPS = RANK_BITS;
    localparam int STEP_BITS   = $clog2(LONG_STEPS + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RANKS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EBYTES = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OWN    = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CFG_START,
        ST_CFG_DIV,
        ST_CFG_SPLIT,
        ST_CHECK,
        ST_LO_START,
        ST_LO_WAIT,
        ST_HI_START,
        ST_HI_WAIT,
        ST_SEG_CNT,
        ST_SEG_MUL,
        ST_SEG_EMIT,
        ST_ERR
    } brs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_start;
        logic cfg_capture;
        logic item_load;
        logic loc_start;
        logic loc_capture;
        logic loc_sel;
        logic seg_count;
        logic seg_mul;
        logic emit;
        logic emit_err;
    } brs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;
        logic div_fin;
        logic seg_final;
        logic out_free;
    } brs_sts_t;

endpackage

/* rtl/brs_div.sv */
// Restoring divider, one quotient bit per cycle, with a short mode for small quotients.
module brs_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             short_div,
    input  logic [brs_pkg::INDEX_BITS-1:0]   dividend,
    input  logic [brs_pkg::INDEX_BITS-1:0]   divisor,
    output logic [brs_pkg::INDEX_BITS-1:0]   quotient,
    output logic [brs_pkg::INDEX_BITS-1:0]   remainder,
    output logic                             fin
);

    logic                             busy_reg;
    logic                             fin_reg;
    logic [brs_pkg::STEP_BITS-1:0]    steps_reg;
    logic [brs_pkg::INDEX_BITS-1:0]   divisor_reg;
    logic [brs_pkg::INDEX_BITS-1:0]   rem_reg;
    logic [brs_pkg::INDEX_BITS-1:0]   rem_next;
    logic [brs_pkg::INDEX_BITS-1:0]   dq_reg;
    logic [brs_pkg::INDEX_BITS-1:0]   dq_next;
    logic [brs_pkg::INDEX_BITS:0]     shifted;
    logic [brs_pkg::INDEX_BITS:0]     diff;
    logic                             fits;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted  = {rem_reg, dq_reg[brs_pkg::INDEX_BITS-1]};
        diff     = shifted - {1'b0, divisor_reg};
        fits     = (shifted >= {1'b0, divisor_reg});
        rem_next = fits ? diff[brs_pkg::INDEX_BITS-1:0] : shifted[brs_pkg::INDEX_BITS-1:0];
        dq_next  = {dq_reg[brs_pkg::INDEX_BITS-2:0], fits};
    end

    // Step sequencing. In short mode the quotient is known to fit in SHORT_STEPS bits,
    // so the upper dividend bits go straight into the partial remainder.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            steps_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            fin_reg   <= 1'b0;
            steps_reg <= short_div ? brs_pkg::STEP_BITS'(brs_pkg::SHORT_STEPS)
                                   : brs_pkg::STEP_BITS'(brs_pkg::LONG_STEPS);
        end
        else if (busy_reg)
        begin
            steps_reg <= steps_reg - 1'b1;
            if (steps_reg == brs_pkg::STEP_BITS'(1))
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    // Partial remainder and combined dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            if (short_div)
            begin
                rem_reg <= dividend >> brs_pkg::SHORT_STEPS;
                dq_reg  <= dividend << (brs_pkg::INDEX_BITS - brs_pkg::SHORT_STEPS);
            end
            else
            begin
                rem_reg <= '0;
                dq_reg  <= dividend;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign quotient  = dq_reg;
    assign remainder = rem_reg;
    assign fin       = fin_reg;

endmodule

/* rtl/brs_datapath.sv */
// Datapath: configuration, derived split values, index lookup and segment output register.
module brs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  brs_pkg::brs_cmd_t                   cmd,
    output brs_pkg::brs_sts_t                   sts,
    input  logic                                cfg_we,
    input  logic [brs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [brs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                opcode,
    input  logic [brs_pkg::INDEX_BITS-1:0]      lo_index,
    input  logic [brs_pkg::INDEX_BITS-1:0]      hi_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic                                op_out,
    output logic [brs_pkg::RANK_BITS-1:0]       target_rank,
    output logic [brs_pkg::BYTE_BITS-1:0]       target_byte_offset,
    output logic [brs_pkg::BYTE_BITS-1:0]       segment_bytes,
    output logic [brs_pkg::BYTE_BITS-1:0]       buffer_byte_offset,
    output logic                                last
);

    // Configuration and derived values.
    logic [brs_pkg::INDEX_BITS-1:0]      total_reg;
    logic [brs_pkg::RCNT_BITS-1:0]       ranks_reg;
    logic [brs_pkg::RCNT_BITS-1:0]       ranks_next;
    logic [brs_pkg::EB_BITS-1:0]         ebytes_reg;
    logic [brs_pkg::INDEX_BITS-1:0]      base_reg;
    logic [brs_pkg::RANK_BITS-1:0]       extra_reg;
    logic [brs_pkg::INDEX_BITS-1:0]      split_reg;
    logic [brs_pkg::SPLIT_PROD_BITS-1:0] split_prod;

    // Request and lookup results.
    logic                                op_reg;
    logic [brs_pkg::INDEX_BITS-1:0]      lo_reg;
    logic [brs_pkg::INDEX_BITS-1:0]      hi_reg;
    logic                                first_reg;
    logic [brs_pkg::RANK_BITS-1:0]       rl_reg;
    logic [brs_pkg::RANK_BITS-1:0]       rh_reg;
    logic [brs_pkg::INDEX_BITS-1:0]      ol_reg;
    logic [brs_pkg::INDEX_BITS-1:0]      oh_reg;

    // Segment walk.
    logic [brs_pkg::RANK_BITS-1:0]       r_reg;
    logic [brs_pkg::CNT_BITS-1:0]        cnt_reg;
    logic [brs_pkg::CNT_BITS-1:0]        cnt_next;
    logic [brs_pkg::BYTE_BITS-1:0]       toff_reg;
    logic [brs_pkg::BYTE_BITS-1:0]       toff_next;
    logic [brs_pkg::BYTE_BITS-1:0]       nb_reg;
    logic [brs_pkg::BYTE_BITS-1:0]       boff_reg;
    logic [brs_pkg::NB_PROD_BITS-1:0]    nb_prod;
    logic [brs_pkg::TOFF_PROD_BITS-1:0]  toff_prod;
    logic [brs_pkg::CNT_BITS-1:0]        rank_len;
    logic                                seg_first;
    logic                                seg_final;

    // Divider hookup.
    logic [brs_pkg::INDEX_BITS-1:0]      loc_idx;
    logic                                loc_first;
    logic [brs_pkg::INDEX_BITS-1:0]      div_dividend;
    logic [brs_pkg::INDEX_BITS-1:0]      div_divisor;
    logic [brs_pkg::INDEX_BITS-1:0]      quo;
    logic [brs_pkg::INDEX_BITS-1:0]      rem;
    logic                                div_fin;
    logic [brs_pkg::RCNT_BITS-1:0]       rank_sum;
    logic [brs_pkg::RANK_BITS-1:0]       loc_rank;
    logic [brs_pkg::INDEX_BITS-1:0]      loc_off;

    // Output register.
    logic                                out_valid_reg;
    logic                                status_reg;
    logic                                op_out_reg;
    logic [brs_pkg::RANK_BITS-1:0]       rank_out_reg;
    logic [brs_pkg::BYTE_BITS-1:0]       toff_out_reg;
    logic [brs_pkg::BYTE_BITS-1:0]       nb_out_reg;
    logic [brs_pkg::BYTE_BITS-1:0]       boff_out_reg;
    logic                                last_reg;

    // A rank count of zero means one rank; counts above the limit saturate.
    always_comb
    begin
        ranks_next = cfg_data[brs_pkg::RCNT_BITS-1:0];
        if (ranks_next == '0)
        begin
            ranks_next = brs_pkg::RCNT_BITS'(1);
        end
        else if (ranks_next > brs_pkg::RCNT_BITS'(brs_pkg::MAX_RANKS))
        begin
            ranks_next = brs_pkg::RCNT_BITS'(brs_pkg::MAX_RANKS);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= brs_pkg::INDEX_BITS'(1);
            ranks_reg  <= brs_pkg::RCNT_BITS'(1);
            ebytes_reg <= brs_pkg::EB_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                brs_pkg::CFG_TOTAL:  total_reg  <= cfg_data;
                brs_pkg::CFG_RANKS:  ranks_reg  <= ranks_next;
                brs_pkg::CFG_EBYTES: ebytes_reg <= cfg_data[brs_pkg::EB_BITS-1:0];
                brs_pkg::CFG_OWN:
                begin
                    // The requesting rank has no effect on the mapping.
                end
                default:
                begin
                end
            endcase
        end
    end

    // Elements held before the first short rank: extra * (base + 1).
    assign split_prod = brs_pkg::SPLIT_PROD_BITS'(rem[brs_pkg::RANK_BITS-1:0])
                      * brs_pkg::SPLIT_PROD_BITS'({1'b0, quo} + 1'b1);

    // Derived per-rank counts, captured when the configuration division ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= brs_pkg::INDEX_BITS'(1);
            extra_reg <= '0;
            split_reg <= '0;
        end
        else if (cmd.cfg_capture)
        begin
            base_reg  <= quo;
            extra_reg <= rem[brs_pkg::RANK_BITS-1:0];
            split_reg <= split_prod[brs_pkg::INDEX_BITS-1:0];
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            op_reg <= opcode;
            lo_reg <= lo_index;
            hi_reg <= hi_index;
        end
    end

    assign sts.invalid = (lo_reg >= total_reg) || (hi_reg >= total_reg) || (hi_reg < lo_reg);

    // Divider operands: the configuration split, or an index lookup in either the
    // long-rank region or the short-rank region.
    always_comb
    begin
        loc_idx   = cmd.loc_sel ? hi_reg : lo_reg;
        loc_first = (loc_idx < split_reg);
        if (cmd.cfg_start)
        begin
            div_dividend = total_reg;
            div_divisor  = brs_pkg::INDEX_BITS'(ranks_reg);
        end
        else if (loc_first)
        begin
            div_dividend = loc_idx;
            div_divisor  = base_reg + 1'b1;
        end
        else
        begin
            div_dividend = loc_idx - split_reg;
            div_divisor  = base_reg;
        end
    end

    brs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.cfg_start | cmd.loc_start),
        .short_div (!cmd.cfg_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (quo),
        .remainder (rem),
        .fin       (div_fin)
    );

    assign sts.div_fin = div_fin;

    // Rank and offset of a looked-up index. Short ranks follow the extra ones.
    always_comb
    begin
        rank_sum = {1'b0, extra_reg} + {1'b0, quo[brs_pkg::RANK_BITS-1:0]};
        if (first_reg)
        begin
            loc_rank = quo[brs_pkg::RANK_BITS-1:0];
            loc_off  = rem;
        end
        else if (base_reg == '0)
        begin
            loc_rank = '0;
            loc_off  = '0;
        end
        else
        begin
            loc_rank = rank_sum[brs_pkg::RANK_BITS-1:0];
            loc_off  = rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.loc_start)
        begin
            first_reg <= loc_first;
        end
        if (cmd.loc_capture)
        begin
            if (cmd.loc_sel)
            begin
                rh_reg   <= loc_rank;
                oh_reg   <= loc_off;
                r_reg    <= rl_reg;
                boff_reg <= '0;
            end
            else
            begin
                rl_reg <= loc_rank;
                ol_reg <= loc_off;
            end
        end
        else if (cmd.emit)
        begin
            r_reg    <= r_reg + 1'b1;
            boff_reg <= boff_reg + nb_reg;
        end
    end

    // Element count of the current segment.
    always_comb
    begin
        seg_first = (r_reg == rl_reg);
        seg_final = (r_reg == rh_reg);
        rank_len  = {1'b0, base_reg} + brs_pkg::CNT_BITS'(r_reg < extra_reg);
        toff_prod = brs_pkg::TOFF_PROD_BITS'(ol_reg) * brs_pkg::TOFF_PROD_BITS'(ebytes_reg);
        toff_next = seg_first ? toff_prod[brs_pkg::BYTE_BITS-1:0] : '0;
        if (seg_first && seg_final)
        begin
            cnt_next = {1'b0, hi_reg} - {1'b0, lo_reg} + 1'b1;
        end
        else if (seg_first)
        begin
            cnt_next = rank_len - {1'b0, ol_reg};
        end
        else if (seg_final)
        begin
            cnt_next = {1'b0, oh_reg} + 1'b1;
        end
        else
        begin
            cnt_next = rank_len;
        end
    end

    assign sts.seg_final = seg_final;

    assign nb_prod = brs_pkg::NB_PROD_BITS'(cnt_reg) * brs_pkg::NB_PROD_BITS'(ebytes_reg);

    // Segment count, then its byte size in the cycle after.
    always_ff @(posedge clk)
    begin
        if (cmd.seg_count)
        begin
            cnt_reg  <= cnt_next;
            toff_reg <= toff_next;
        end
        if (cmd.seg_mul)
        begin
            nb_reg <= nb_prod[brs_pkg::BYTE_BITS-1:0];
        end
    end

    // Output valid: set on a new result, cleared once the result transfers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;

    // Output payload. An error result carries zeros in every segment field.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg   <= cmd.emit_err;
            op_out_reg   <= op_reg;
            rank_out_reg <= cmd.emit_err ? '0 : r_reg;
            toff_out_reg <= cmd.emit_err ? '0 : toff_reg;
            nb_out_reg   <= cmd.emit_err ? '0 : nb_reg;
            boff_out_reg <= cmd.emit_err ? '0 : boff_reg;
            last_reg     <= cmd.emit_err || seg_final;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign op_out             = op_out_reg;
    assign target_rank        = rank_out_reg;
    assign target_byte_offset = toff_out_reg;
    assign segment_bytes      = nb_out_reg;
    assign buffer_byte_offset = boff_out_reg;
    assign last               = last_reg;

endmodule

/* rtl/brs_ctrl.sv */
// Controller state machine: sequences configuration division, lookups and segment output.
module brs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                in_valid,
    output logic                in_ready,
    output brs_pkg::brs_cmd_t   cmd,
    input  brs_pkg::brs_sts_t   sts
);

    brs_pkg::brs_state_t state_reg;
    brs_pkg::brs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brs_pkg::ST_IDLE:
            begin
                if (cfg_we)
                    state_next = brs_pkg::ST_CFG_START;
                else if (in_valid)
                    state_next = brs_pkg::ST_CHECK;
            end
            brs_pkg::ST_CFG_START:
            begin
                if (!cfg_we)
                    state_next = brs_pkg::ST_CFG_DIV;
            end
            brs_pkg::ST_CFG_DIV:
            begin
                if (cfg_we)
                    state_next = brs_pkg::ST_CFG_START;
                else if (sts.div_fin)
                    state_next = brs_pkg::ST_CFG_SPLIT;
            end
            brs_pkg::ST_CFG_SPLIT:
            begin
                state_next = cfg_we ? brs_pkg::ST_CFG_START : brs_pkg::ST_IDLE;
            end
            brs_pkg::ST_CHECK:
            begin
                state_next = sts.invalid ? brs_pkg::ST_ERR : brs_pkg::ST_LO_START;
            end
            brs_pkg::ST_LO_START: state_next = brs_pkg::ST_LO_WAIT;
            brs_pkg::ST_LO_WAIT:
            begin
                if (sts.div_fin)
                    state_next = brs_pkg::ST_HI_START;
            end
            brs_pkg::ST_HI_START: state_next = brs_pkg::ST_HI_WAIT;
            brs_pkg::ST_HI_WAIT:
            begin
                if (sts.div_fin)
                    state_next = brs_pkg::ST_SEG_CNT;
            end
            brs_pkg::ST_SEG_CNT: state_next = brs_pkg::ST_SEG_MUL;
            brs_pkg::ST_SEG_MUL: state_next = brs_pkg::ST_SEG_EMIT;
            brs_pkg::ST_SEG_EMIT:
            begin
                if (sts.out_free)
                    state_next = sts.seg_final ? brs_pkg::ST_IDLE : brs_pkg::ST_SEG_CNT;
            end
            brs_pkg::ST_ERR:
            begin
                if (sts.out_free)
                    state_next = brs_pkg::ST_IDLE;
            end
            default: state_next = brs_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            brs_pkg::ST_IDLE:
            begin
                in_ready      = !cfg_we;
                cmd.item_load = in_valid && !cfg_we;
            end
            brs_pkg::ST_CFG_START: cmd.cfg_start = !cfg_we;
            brs_pkg::ST_CFG_DIV:
            begin
            end
            brs_pkg::ST_CFG_SPLIT: cmd.cfg_capture = 1'b1;
            brs_pkg::ST_CHECK:
            begin
            end
            brs_pkg::ST_LO_START:
            begin
                cmd.loc_start = 1'b1;
                cmd.loc_sel   = 1'b0;
            end
            brs_pkg::ST_LO_WAIT:
            begin
                cmd.loc_capture = sts.div_fin;
                cmd.loc_sel     = 1'b0;
            end
            brs_pkg::ST_HI_START:
            begin
                cmd.loc_start = 1'b1;
                cmd.loc_sel   = 1'b1;
            end
            brs_pkg::ST_HI_WAIT:
            begin
                cmd.loc_capture = sts.div_fin;
                cmd.loc_sel     = 1'b1;
            end
            brs_pkg::ST_SEG_CNT: cmd.seg_count = 1'b1;
            brs_pkg::ST_SEG_MUL: cmd.seg_mul = 1'b1;
            brs_pkg::ST_SEG_EMIT: cmd.emit = sts.out_free;
            brs_pkg::ST_ERR:
            begin
                cmd.emit     = sts.out_free;
                cmd.emit_err = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/block_distribution_range_splitter_core.sv */
// Top level of the block distribution range splitter: controller plus datapath.
//
//   Channel   Handshake             Payload
//   -------   -------------------   ------------------------------------------------
//   in        in_valid / in_ready   opcode, lo_index, hi_index
//   out       out_valid / out_ready status, op_out, target_rank, target_byte_offset,
//                                   segment_bytes, buffer_byte_offset, last
//   cfg       cfg_we (no wait)      cfg_index, cfg_data
//
// After its transfer a request passes one range check state, then two 6-step divisions
// on the shared divider, then the count, multiply and emit states for each segment,
// plus any output stall. An invalid range goes from the check to the error state.
// A configuration write starts a 32-step division of the element count by the rank
// count; in_ready stays low during the writes and until the split values are captured.
// Reset loads one element over one rank with one-byte elements.
// A stalled output holds the segment walk; a new request is taken while the last
// result still waits in the output register.
module block_distribution_range_splitter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [brs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [brs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic [brs_pkg::INDEX_BITS-1:0]      lo_index,
    input  logic [brs_pkg::INDEX_BITS-1:0]      hi_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic                                op_out,
    output logic [brs_pkg::RANK_BITS-1:0]       target_rank,
    output logic [brs_pkg::BYTE_BITS-1:0]       target_byte_offset,
    output logic [brs_pkg::BYTE_BITS-1:0]       segment_bytes,
    output logic [brs_pkg::BYTE_BITS-1:0]       buffer_byte_offset,
    output logic                                last
);

    brs_pkg::brs_cmd_t cmd;
    brs_pkg::brs_sts_t sts;

    brs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    brs_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .opcode             (opcode),
        .lo_index           (lo_index),
        .hi_index           (hi_index),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .op_out             (op_out),
        .target_rank        (target_rank),
        .target_byte_offset (target_byte_offset),
        .segment_bytes      (segment_bytes),
        .buffer_byte_offset (buffer_byte_offset),
        .last               (last)
    );

`ifndef SYNTHESIS
    // After a request transfers, the block is busy on it and in_ready is low in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted on consecutive cycles");

    // A configuration write blocks requests until the split is recomputed.
    a_busy_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("request path open right after a configuration write");

    // An error result is a single, final result with empty segment fields.
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (last && target_rank == '0 && segment_bytes == '0
                                   && buffer_byte_offset == '0))
        else $error("error result with segment data or without last");
`endif

endmodule

/* verif/brs_range_checker.sv */
// Checker for the range splitter core: tracks the registers, predicts segments, compares results.
module brs_range_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [brs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [brs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                opcode,
    input  logic [brs_pkg::INDEX_BITS-1:0]      lo_index,
    input  logic [brs_pkg::INDEX_BITS-1:0]      hi_index,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                status,
    input  logic                                op_out,
    input  logic [brs_pkg::RANK_BITS-1:0]       target_rank,
    input  logic [brs_pkg::BYTE_BITS-1:0]       target_byte_offset,
    input  logic [brs_pkg::BYTE_BITS-1:0]       segment_bytes,
    input  logic [brs_pkg::BYTE_BITS-1:0]       buffer_byte_offset,
    input  logic                                last,
    output int                                  mismatches,
    output int                                  outstanding
);

    typedef longint unsigned u64_t;

    // One result transfer as seen on the output channel.
    typedef struct packed {
        logic                            status;
        logic                            op;
        logic [brs_pkg::RANK_BITS-1:0]   rank;
        logic [brs_pkg::BYTE_BITS-1:0]   target_offset;
        logic [brs_pkg::BYTE_BITS-1:0]   nbytes;
        logic [brs_pkg::BYTE_BITS-1:0]   buffer_offset;
        logic                            last;
    } segment_t;

    localparam logic SEG_OK        = 1'b0;
    localparam logic SEG_RANGE_ERR = 1'b1;

    // Shadow copy of the registers and the split derived from them.
    logic [brs_pkg::INDEX_BITS-1:0]  total_elems;
    logic [brs_pkg::RCNT_BITS-1:0]   rank_cnt;
    logic [brs_pkg::EB_BITS-1:0]     elem_bytes;
    u64_t                            per_rank;
    u64_t                            extra_ranks;

    segment_t                        segments_due[$];
    int                              fail_cnt;

    // Recompute the per-rank element count and the number of ranks that hold one more.
    function automatic void rederive();
        u64_t p;
        p = u64_t'(rank_cnt);
        if (p == 0) p = 1;
        if (p > brs_pkg::MAX_RANKS) p = brs_pkg::MAX_RANKS;
        per_rank    = u64_t'(total_elems) / p;
        extra_ranks = u64_t'(total_elems) % p;
    endfunction

    function automatic u64_t rank_length(input u64_t r);
        return per_rank + ((r < extra_ranks) ? 1 : 0);
    endfunction

    // Map a global index to its owning rank and the element offset within that rank.
    function automatic void find_owner(input u64_t idx, output u64_t rank, output u64_t ofs);
        u64_t wide;
        u64_t split;
        wide  = per_rank + 1;
        split = extra_ranks * wide;
        if (idx < split)
        begin
            rank = idx / wide;
            ofs  = idx % wide;
        end
        else if (per_rank != 0)
        begin
            rank = extra_ranks + (idx - split) / per_rank;
            ofs  = (idx - split) % per_rank;
        end
        else
        begin
            rank = 0;
            ofs  = 0;
        end
    endfunction

    function automatic void push_segment(input logic st, input logic op, input u64_t rank,
                                         input u64_t toff, input u64_t nb, input u64_t boff,
                                         input logic fin);
        segment_t s;
        s.status        = st;
        s.op            = op;
        s.rank          = rank[brs_pkg::RANK_BITS-1:0];
        s.target_offset = toff[brs_pkg::BYTE_BITS-1:0];
        s.nbytes        = nb[brs_pkg::BYTE_BITS-1:0];
        s.buffer_offset = boff[brs_pkg::BYTE_BITS-1:0];
        s.last          = fin;
        segments_due.push_back(s);
    endfunction

    // Split one request into the segments that the block must produce, in rank order.
    function automatic void predict_segments(input logic op, input u64_t lo, input u64_t hi);
        u64_t                            rl, ol, rh, oh, r, n, eb, total;
        logic [brs_pkg::BYTE_BITS-1:0]   boff;
        logic [brs_pkg::BYTE_BITS-1:0]   nb;
        int                              k;
        eb    = u64_t'(elem_bytes);
        total = u64_t'(total_elems);
        if (lo >= total || hi >= total || hi < lo)
        begin
            push_segment(SEG_RANGE_ERR, op, 0, 0, 0, 0, 1'b1);
            return;
        end
        find_owner(lo, rl, ol);
        find_owner(hi, rh, oh);
        if (rl == rh)
        begin
            push_segment(SEG_OK, op, rl, ol * eb, (hi - lo + 1) * eb, 0, 1'b1);
            return;
        end
        // Head segment runs from the first offset to the end of its rank.
        n    = rank_length(rl) - ol;
        boff = brs_pkg::BYTE_BITS'(n * eb);
        push_segment(SEG_OK, op, rl, ol * eb, n * eb, 0, 1'b0);
        k = 1;
        // Whole ranks in between.
        for (r = rl + 1; r < rh && k < brs_pkg::MAX_RANKS - 1; r++)
        begin
            nb = brs_pkg::BYTE_BITS'(rank_length(r) * eb);
            push_segment(SEG_OK, op, r, 0, u64_t'(nb), u64_t'(boff), 1'b0);
            boff = boff + nb;
            k++;
        end
        // Tail segment ends at the last offset.
        push_segment(SEG_OK, op, rh, 0, (oh + 1) * eb, u64_t'(boff), 1'b1);
    endfunction

    task automatic check_field(input string name, input logic [brs_pkg::BYTE_BITS-1:0] want_v,
                               input logic [brs_pkg::BYTE_BITS-1:0] got_v);
        if (got_v !== want_v)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
        end
    endtask

    // Follow register writes, predict on each request transfer, compare each result transfer.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        segment_t got;
        segment_t want;
        if (!rst_n)
        begin
            total_elems = 1;
            rank_cnt    = 1;
            elem_bytes  = 1;
            rederive();
            segments_due.delete();
            fail_cnt    = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    brs_pkg::CFG_TOTAL:  total_elems = cfg_data[brs_pkg::INDEX_BITS-1:0];
                    brs_pkg::CFG_RANKS:  rank_cnt    = cfg_data[brs_pkg::RCNT_BITS-1:0];
                    brs_pkg::CFG_EBYTES: elem_bytes  = cfg_data[brs_pkg::EB_BITS-1:0];
                    // The requesting rank does not change the mapping.
                    brs_pkg::CFG_OWN:    ;
                    default:             ;
                endcase
                rederive();
            end
            if (in_valid && in_ready)
                predict_segments(opcode, u64_t'(lo_index), u64_t'(hi_index));
            if (out_valid && out_ready)
            begin
                got = {status, op_out, target_rank, target_byte_offset, segment_bytes,
                       buffer_byte_offset, last};
                if (segments_due.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: result with none expected: expected nothing, actual %0h",
                             $time, got);
                end
                else
                begin
                    want = segments_due.pop_front();
                    check_field("status", brs_pkg::BYTE_BITS'(want.status),
                                brs_pkg::BYTE_BITS'(got.status));
                    check_field("op_out", brs_pkg::BYTE_BITS'(want.op),
                                brs_pkg::BYTE_BITS'(got.op));
                    check_field("target_rank", brs_pkg::BYTE_BITS'(want.rank),
                                brs_pkg::BYTE_BITS'(got.rank));
                    check_field("target_byte_offset", want.target_offset, got.target_offset);
                    check_field("segment_bytes", want.nbytes, got.nbytes);
                    check_field("buffer_byte_offset", want.buffer_offset, got.buffer_offset);
                    check_field("last", brs_pkg::BYTE_BITS'(want.last),
                                brs_pkg::BYTE_BITS'(got.last));
                end
            end
            mismatches  <= fail_cnt;
            outstanding <= segments_due.size();
        end
    end

endmodule

/* verif/block_distribution_range_splitter_core_tb.sv */
// Testbench top for the range splitter core: clock, reset, stimulus, back-pressure and verdict.
module block_distribution_range_splitter_core_tb;

    typedef longint unsigned u64_t;

    localparam logic OP_GET        = 1'b0;
    localparam logic OP_PUT        = 1'b1;
    localparam int   LONG_HOLD     = 400;
    localparam int   IDLE_LIMIT    = 4000;
    localparam int   RANDOM_PHASES = 12;
    localparam int   PHASE_ITEMS   = 28;
    localparam int   SETTLE_CYCLES = 60;
    localparam u64_t INDEX_SPACE   = 64'h1_0000_0000;
    localparam u64_t INDEX_MAX     = 64'hFFFF_FFFF;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [brs_pkg::CFG_IDX_BITS-1:0]    cfg_index = brs_pkg::CFG_TOTAL;
    logic [brs_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic                                opcode = OP_GET;
    logic [brs_pkg::INDEX_BITS-1:0]      lo_index = '0;
    logic [brs_pkg::INDEX_BITS-1:0]      hi_index = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic                                status;
    logic                                op_out;
    logic [brs_pkg::RANK_BITS-1:0]       target_rank;
    logic [brs_pkg::BYTE_BITS-1:0]       target_byte_offset;
    logic [brs_pkg::BYTE_BITS-1:0]       segment_bytes;
    logic [brs_pkg::BYTE_BITS-1:0]       buffer_byte_offset;
    logic                                last;
    int                                  mismatches;
    int                                  outstanding;

    // Requests to the result side: long hold-offs and the idle-free tail.
    int                                  long_holds_asked = 0;
    logic                                quiet_tail = 1'b0;

    // Request-side view of the current setting, used to shape index ranges.
    u64_t                                cur_total = 1;
    u64_t                                cur_stride = 1;
    int                                  gap_pct = 30;

    block_distribution_range_splitter_core u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .lo_index           (lo_index),
        .hi_index           (hi_index),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .op_out             (op_out),
        .target_rank        (target_rank),
        .target_byte_offset (target_byte_offset),
        .segment_bytes      (segment_bytes),
        .buffer_byte_offset (buffer_byte_offset),
        .last               (last)
    );

    brs_range_checker u_checker (.*);

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Uniform pick in [0, n-1], n at least 1; spans beyond the index space are clipped.
    function automatic u64_t pick_below(input u64_t n);
        if (n > INDEX_SPACE) n = INDEX_SPACE;
        return u64_t'($urandom_range(0, 32'(n - 1)));
    endfunction

    // Offer one request and hold it until the transfer happens; valid stays high afterwards.
    task automatic send_request(input logic op, input u64_t lo, input u64_t hi);
        in_valid <= 1'b1;
        opcode   <= op;
        lo_index <= lo[brs_pkg::INDEX_BITS-1:0];
        hi_index <= hi[brs_pkg::INDEX_BITS-1:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Send a request, then maybe leave a short gap on the request side.
    task automatic offer(input logic op, input u64_t lo, input u64_t hi);
        send_request(op, lo, hi);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every predicted result has been seen.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [brs_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [brs_pkg::CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Reprogram all four registers once the block has gone idle.
    task automatic write_config(input u64_t total, input int ranks, input int ebytes,
                                input int own);
        int eff;
        drain_results();
        write_reg(brs_pkg::CFG_TOTAL, total[brs_pkg::CFG_DATA_BITS-1:0]);
        write_reg(brs_pkg::CFG_RANKS, brs_pkg::CFG_DATA_BITS'(ranks));
        write_reg(brs_pkg::CFG_EBYTES, brs_pkg::CFG_DATA_BITS'(ebytes));
        write_reg(brs_pkg::CFG_OWN, brs_pkg::CFG_DATA_BITS'(own));
        cfg_we <= 1'b0;
        eff = ranks & 7'h7F;
        if (eff == 0) eff = 1;
        if (eff > brs_pkg::MAX_RANKS) eff = brs_pkg::MAX_RANKS;
        cur_total  = total & INDEX_MAX;
        cur_stride = cur_total / u64_t'(eff);
        if (cur_stride == 0) cur_stride = 1;
    endtask

    task automatic random_config();
        u64_t total;
        int   ranks;
        int   ebytes;
        case ($urandom_range(0, 5))
            0:       total = u64_t'($urandom_range(1, 16));
            1, 2:    total = u64_t'($urandom_range(17, 3000));
            3:       total = u64_t'($urandom_range(3001, 1000000));
            4:       total = u64_t'($urandom);
            default: total = INDEX_MAX - u64_t'($urandom_range(0, 1000));
        endcase
        ranks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
        case ($urandom_range(0, 7))
            0:       ebytes = 0;
            1:       ebytes = $urandom_range(4097, 8191);
            2:       ebytes = $urandom_range(1, 4096);
            default: ebytes = $urandom_range(1, 16);
        endcase
        write_config(total, ranks, ebytes, $urandom_range(0, 63));
    endtask

    // Mostly well-formed ranges of assorted spans; the rest reversed, past the end, or noise.
    task automatic random_request();
        u64_t lo;
        u64_t hi;
        u64_t span;
        u64_t beyond;
        int   kind;
        logic op;
        op   = $urandom_range(0, 1) ? OP_PUT : OP_GET;
        kind = $urandom_range(0, 99);
        lo   = u64_t'($urandom);
        hi   = u64_t'($urandom);
        if (cur_total != 0 && kind < 62)
        begin
            lo = pick_below(cur_total);
            case ($urandom_range(0, 4))
                0:       span = 0;
                1:       span = pick_below(cur_stride + 1);
                2:       span = pick_below(cur_stride * 3 + 1);
                3:       span = pick_below(cur_total);
                default:
                begin
                    lo   = 0;
                    span = cur_total - 1;
                end
            endcase
            hi = lo + span;
            if (hi >= cur_total) hi = cur_total - 1;
        end
        else if (cur_total >= 2 && kind < 76)
        begin
            hi = pick_below(cur_total - 1);
            lo = hi + 1 + pick_below(cur_total - 1 - hi);
        end
        else if (cur_total < INDEX_MAX && kind < 90)
        begin
            beyond = cur_total + pick_below(INDEX_SPACE - cur_total);
            if ($urandom_range(0, 1))
            begin
                lo = beyond;
                hi = beyond + pick_below(INDEX_SPACE - beyond);
            end
            else
            begin
                lo = (cur_total == 0) ? 0 : pick_below(cur_total);
                hi = beyond;
            end
        end
        offer(op, lo, hi);
    endtask

    // Result side: stretches of varying stall density, long hold-offs on request, quiet tail.
    initial
    begin : result_sink
        int holds_done;
        int stall_left;
        int stretch_left;
        int stall_pct;
        holds_done   = 0;
        stall_left   = 0;
        stretch_left = 0;
        stall_pct    = 0;
        forever
        begin
            @(posedge clk);
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(30, 200);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            stretch_left--;
            if (quiet_tail)
            begin
                out_ready <= 1'b1;
            end
            else if (long_holds_asked != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Abort when no transfer happens on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int item;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: a single element on a single rank.
        offer(OP_GET, 0, 0);
        offer(OP_PUT, 0, 0);
        offer(OP_GET, 0, 1);
        offer(OP_PUT, 1, 1);
        offer(OP_GET, INDEX_MAX, INDEX_MAX);

        // Largest array over the most ranks: full span, top element, reversed, boundaries.
        write_config(INDEX_MAX, 64, 4096, 63);
        offer(OP_GET, 0, INDEX_MAX - 1);
        offer(OP_PUT, INDEX_MAX - 1, INDEX_MAX - 1);
        offer(OP_GET, 5, 4);
        offer(OP_PUT, 0, INDEX_MAX);
        offer(OP_GET, 64'd4227858431, 64'd4227858432);
        offer(OP_PUT, 3, 64'd67108866);

        // One rank with the widest element size, so byte counts wrap.
        write_config(INDEX_MAX, 1, 8191, 32);
        offer(OP_GET, 0, INDEX_MAX - 1);
        offer(OP_PUT, 1, INDEX_MAX - 1);

        // Zero rank count and zero-byte elements.
        write_config(10, 0, 0, 0);
        offer(OP_GET, 0, 9);
        offer(OP_PUT, 3, 7);

        // Rank count above the maximum with fewer elements than ranks.
        write_config(5, 127, 8191, 63);
        offer(OP_GET, 0, 4);
        offer(OP_PUT, 2, 2);
        offer(OP_GET, 4, 5);

        // Empty array: every request is a range error.
        write_config(0, 3, 1, 0);
        offer(OP_GET, 0, 0);
        offer(OP_PUT, 7, 3);

        // Uneven split with a few extra elements.
        write_config(100, 7, 3, 5);
        offer(OP_GET, 0, 99);
        offer(OP_PUT, 13, 14);
        offer(OP_GET, 28, 43);

        // Random settings, each followed by a batch of random requests.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_config();
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            if (phase == 3) gap_pct = 0;
            if (phase == RANDOM_PHASES - 1)
            begin
                gap_pct    = 0;
                quiet_tail <= 1'b1;
            end
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                // Hold the result side off while requests keep coming, to fill the block.
                if (phase == 3 && item == 4)
                    long_holds_asked <= long_holds_asked + 1;
                // Let the block run completely dry in the middle of a batch.
                if (phase == 6 && item == PHASE_ITEMS / 2)
                    drain_results();
                random_request();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
